// ===== rtl/bsfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bsfr_pkg
// Shared types and constants of the byte stream find and replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfr_pkg;

	localparam int PATTERN_DEPTH_DEF = 8;
	localparam int MAX_REPLACEMENT   = 8;
	localparam int CFG_DATA_W        = 64;
	localparam int LEN_W             = 4;
	localparam int REPL_IDX_W        = 3;

	typedef logic [1:0] cfg_index_t;

	localparam cfg_index_t REG_PATTERN_BYTES     = 2'd0;
	localparam cfg_index_t REG_PATTERN_LENGTH    = 2'd1;
	localparam cfg_index_t REG_REPLACEMENT_BYTES = 2'd2;
	localparam cfg_index_t REG_REPLACEMENT_LEN   = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_end;
		logic       stream_end;
	} out_beat_t;

	typedef struct packed {
		logic       shift;
		logic [7:0] in_byte;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REPL,
		ST_FLUSH
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/bsfr_stream_if.sv =====
// ----------------------------------------------------------------------------
// bsfr_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsfr_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/bsfr_cell.sv =====
// ----------------------------------------------------------------------------
// bsfr_cell
// One window position: holds a byte, takes the incoming byte when it is the
// append position, shifts toward the oldest end and compares with its
// pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfr_cell (
	input  wire logic                clk,
	input  wire bsfr_pkg::cell_ctl_t ctl,
	input  wire logic                append,
	input  wire logic [7:0]          nbr_byte,
	input  wire logic [7:0]          pat_byte,
	output logic      [7:0]          app_byte,
	output logic                     eq
);

	logic [7:0] byte_q;

	assign app_byte = append ? ctl.in_byte : byte_q;
	assign eq       = (app_byte == pat_byte);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= nbr_byte;
		end else if (append) begin
			byte_q <= ctl.in_byte;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/byte_stream_find_replace.sv =====
// ----------------------------------------------------------------------------
// byte_stream_find_replace
// Replaces every leftmost, non-overlapping occurrence of a pattern in a byte
// stream with a replacement, using a row of window cells.
// ----------------------------------------------------------------------------
// When idle with the output register free, one input byte is taken per cycle
// and gives at most one output beat. A match with a replacement of over one
// byte holds the input while the rest is sent, as does an end of stream byte
// while held bytes flush; the single output register sends one beat per
// cycle when the receiver is ready. Held bytes sit in MAX_PATTERN cells
// shifting to the oldest end; writing pattern_length drops them. The user,
// not the block, must write configuration only while the block is idle.
`default_nettype none

module byte_stream_find_replace #(
	parameter int MAX_PATTERN = bsfr_pkg::PATTERN_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire bsfr_pkg::cfg_index_t              cfg_index,
	input  wire logic [bsfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	bsfr_stream_if.sink                            feed,
	bsfr_stream_if.source                          result
);

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);
	localparam int PAT_W = 8 * MAX_PATTERN;
	localparam int LEN_W = bsfr_pkg::LEN_W;
	localparam int RI_W  = bsfr_pkg::REPL_IDX_W;
	localparam logic [LEN_W-1:0] PLEN_MAX = LEN_W'(MAX_PATTERN);
	localparam logic [LEN_W-1:0] RLEN_MAX = LEN_W'(bsfr_pkg::MAX_REPLACEMENT);

	logic [PAT_W-1:0]               pattern_q;
	logic [CNT_W-1:0]               plen_q;
	logic [bsfr_pkg::CFG_DATA_W-1:0] repl_q;
	logic [LEN_W-1:0]               rlen_q;
	logic [CNT_W-1:0]               count_q;
	logic [RI_W-1:0]                repl_idx_q;
	logic                           eos_q;
	bsfr_pkg::state_t               state_q, state_d;
	logic                           out_valid_q;
	bsfr_pkg::out_beat_t            out_beat_q;

	logic [LEN_W-1:0]   cfg_len;
	logic [CNT_W-1:0]   plen_sat;
	logic [LEN_W-1:0]   rlen_sat;
	logic               plen_wr;

	bsfr_pkg::in_beat_t  in_beat;
	bsfr_pkg::cell_ctl_t cell_ctl;
	logic [MAX_PATTERN-1:0] append_vec;
	logic [MAX_PATTERN-1:0] eq_vec;
	logic [MAX_PATTERN-1:0] in_range;
	logic [7:0]             app_byte [MAX_PATTERN];

	logic eos, full, match, accept, out_free;
	logic go_repl, go_flush, repl_last, flush_last;
	logic load;
	bsfr_pkg::out_beat_t beat;

	assign in_beat  = feed.payload;
	assign eos      = in_beat.end_of_stream;
	assign out_free = !out_valid_q || result.ready;
	assign accept   = feed.valid && feed.ready;

	assign feed.ready     = (state_q == bsfr_pkg::ST_IDLE) && out_free;
	assign result.valid   = out_valid_q;
	assign result.payload = out_beat_q;

	// configuration
	assign cfg_len = cfg_data[LEN_W-1:0];
	assign plen_wr = cfg_we && (cfg_index == bsfr_pkg::REG_PATTERN_LENGTH);

	always_comb begin
		if (cfg_len == '0) begin
			plen_sat = CNT_W'(1);
		end else if (cfg_len > PLEN_MAX) begin
			plen_sat = CNT_W'(MAX_PATTERN);
		end else begin
			plen_sat = CNT_W'(cfg_len);
		end
		rlen_sat = (cfg_len > RLEN_MAX) ? RLEN_MAX : cfg_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= CNT_W'(1);
			repl_q    <= '0;
			rlen_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bsfr_pkg::REG_PATTERN_BYTES:     pattern_q <= cfg_data[PAT_W-1:0];
				bsfr_pkg::REG_PATTERN_LENGTH:    plen_q    <= plen_sat;
				bsfr_pkg::REG_REPLACEMENT_BYTES: repl_q    <= cfg_data;
				bsfr_pkg::REG_REPLACEMENT_LEN:   rlen_q    <= rlen_sat;
			endcase
		end
	end

	// window cells
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic [7:0] nbr;

		if (i == MAX_PATTERN - 1) begin : g_tail
			assign nbr = 8'h00;
		end else begin : g_link
			assign nbr = app_byte[i+1];
		end

		assign append_vec[i] = accept && (count_q == CNT_W'(i));
		assign in_range[i]   = (CNT_W'(i) < plen_q);

		bsfr_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.append   (append_vec[i]),
			.nbr_byte (nbr),
			.pat_byte (pattern_q[8*i +: 8]),
			.app_byte (app_byte[i]),
			.eq       (eq_vec[i])
		);
	end

	assign full  = (({1'b0, count_q} + (CNT_W+1)'(1)) == {1'b0, plen_q});
	assign match = full && (&(eq_vec | ~in_range));

	assign go_repl    = accept && match && (rlen_q > LEN_W'(1));
	assign go_flush   = accept && !match && eos && (count_q != '0);
	assign repl_last  = (({1'b0, repl_idx_q} + (RI_W+1)'(1)) == (RI_W+1)'(rlen_q));
	assign flush_last = (count_q == CNT_W'(1));

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsfr_pkg::ST_IDLE: begin
				if (go_repl) begin
					state_d = bsfr_pkg::ST_REPL;
				end else if (go_flush) begin
					state_d = bsfr_pkg::ST_FLUSH;
				end
			end
			bsfr_pkg::ST_REPL: begin
				if (out_free && repl_last) begin
					state_d = bsfr_pkg::ST_IDLE;
				end
			end
			bsfr_pkg::ST_FLUSH: begin
				if (out_free && flush_last) begin
					state_d = bsfr_pkg::ST_IDLE;
				end
			end
			default: state_d = bsfr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		logic last_now;
		load             = 1'b0;
		beat             = '0;
		cell_ctl.in_byte = in_beat.in_byte;
		cell_ctl.shift   = 1'b0;
		last_now         = 1'b0;
		unique case (state_q)
			bsfr_pkg::ST_IDLE: begin
				if (match) begin
					last_now        = (rlen_q <= LEN_W'(1));
					load            = accept && ((rlen_q != '0) || eos);
					beat.byte_valid = (rlen_q != '0);
					beat.out_byte   = (rlen_q != '0) ? repl_q[7:0] : 8'h00;
				end else begin
					last_now        = !eos || (count_q == '0);
					load            = accept && (eos || full);
					beat.byte_valid = 1'b1;
					beat.out_byte   = app_byte[0];
					cell_ctl.shift  = accept && (eos || full);
				end
				beat.run_end    = last_now;
				beat.stream_end = eos && last_now;
			end
			bsfr_pkg::ST_REPL: begin
				load            = out_free;
				beat.out_byte   = repl_q[8*repl_idx_q +: 8];
				beat.byte_valid = 1'b1;
				beat.run_end    = repl_last;
				beat.stream_end = eos_q && repl_last;
			end
			bsfr_pkg::ST_FLUSH: begin
				load            = out_free;
				cell_ctl.shift  = out_free;
				beat.out_byte   = app_byte[0];
				beat.byte_valid = 1'b1;
				beat.run_end    = flush_last;
				beat.stream_end = flush_last;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bsfr_pkg::ST_IDLE;
			count_q    <= '0;
			repl_idx_q <= '0;
			eos_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			priority if (plen_wr) begin
				count_q <= '0;
			end else if (accept) begin
				if (match) begin
					count_q <= '0;
				end else if (!(eos || full)) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if ((state_q == bsfr_pkg::ST_FLUSH) && out_free) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				repl_idx_q <= RI_W'(1);
				eos_q      <= eos;
			end else if ((state_q == bsfr_pkg::ST_REPL) && out_free) begin
				repl_idx_q <= repl_idx_q + RI_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_beat_q <= beat;
		end
	end

endmodule

`default_nettype wire

// ===== verif/byte_stream_find_replace_chk.sv =====
// ----------------------------------------------------------------------------
// byte_stream_find_replace_chk
// Watches the register port and both channels of the find and replace block.
// Keeps its own copy of the held window and the registers. For every
// accepted input beat it predicts the output beats. It compares each accepted
// output beat, field by field, with the oldest prediction, and reports the
// error count and the number of predictions still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stream_find_replace_chk
	import bsfr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire cfg_index_t            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  feed_valid,
	input  wire logic                  feed_ready,
	input  wire in_beat_t              feed_beat,
	input  wire logic                  result_valid,
	input  wire logic                  result_ready,
	input  wire out_beat_t             result_beat,
	output int                         errors,
	output int                         pending,
	output int                         beats_checked,
	output int                         stream_ends
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [63:0]      pattern_word;
	logic [LEN_W-1:0] pattern_len_reg;
	logic [63:0]      repl_word;
	logic [LEN_W-1:0] repl_len_reg;
	logic [7:0]       held_bytes [8];
	int unsigned      held_count;
	out_beat_t        expected_out_q [$];
	int               err_count;
	int               checked_count;
	int               end_count;

	function automatic out_beat_t release_oldest();
		out_beat_t r;
		r = '{out_byte: held_bytes[0], byte_valid: 1'b1, run_end: 1'b0, stream_end: 1'b0};
		for (int i = 1; i < 8; i++)
			held_bytes[i-1] = held_bytes[i];
		held_bytes[7] = 8'h00;
		if (held_count > 0)
			held_count--;
		return r;
	endfunction

	task automatic predict_results(input in_beat_t beat);
		int unsigned span;
		int unsigned rspan;
		bit          hit;
		out_beat_t   batch [$];
		span  = (pattern_len_reg == 0) ? 1 : ((pattern_len_reg > 8) ? 8 : pattern_len_reg);
		rspan = (repl_len_reg > 8) ? 8 : repl_len_reg;
		if (held_count >= span)
			held_count = 0;
		held_bytes[held_count] = beat.in_byte;
		held_count++;
		if (held_count == span) begin
			hit = 1'b1;
			for (int i = 0; i < span; i++)
				if (held_bytes[i] != pattern_word[i*8 +: 8])
					hit = 1'b0;
			if (hit) begin
				for (int i = 0; i < rspan; i++)
					batch.push_back('{out_byte: repl_word[i*8 +: 8], byte_valid: 1'b1,
						run_end: 1'b0, stream_end: 1'b0});
				held_bytes = '{default: 8'h00};
				held_count = 0;
			end else begin
				batch.push_back(release_oldest());
			end
		end
		if (beat.end_of_stream) begin
			while (held_count > 0)
				batch.push_back(release_oldest());
			// bare end marker
			if (batch.size() == 0)
				batch.push_back('0);
			batch[batch.size()-1].stream_end = 1'b1;
		end
		if (batch.size() > 0)
			batch[batch.size()-1].run_end = 1'b1;
		foreach (batch[k])
			expected_out_q.push_back(batch[k]);
	endtask

	task automatic check_result(input out_beat_t got);
		out_beat_t want;
		if (expected_out_q.size() == 0) begin
			$error("unexpected result beat: out_byte %02h", got.out_byte);
			err_count++;
		end else begin
			want = expected_out_q.pop_front();
			checked_count++;
			if (got.stream_end)
				end_count++;
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
				err_count++;
			end
			if (got.byte_valid !== want.byte_valid) begin
				$error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
				err_count++;
			end
			if (got.run_end !== want.run_end) begin
				$error("run_end: expected %0b, got %0b", want.run_end, got.run_end);
				err_count++;
			end
			if (got.stream_end !== want.stream_end) begin
				$error("stream_end: expected %0b, got %0b", want.stream_end, got.stream_end);
				err_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_word    = '0;
			pattern_len_reg = 4'd1;
			repl_word       = '0;
			repl_len_reg    = '0;
			held_bytes      = '{default: 8'h00};
			held_count      = 0;
			expected_out_q.delete();
			err_count       = 0;
			checked_count   = 0;
			end_count       = 0;
			errors         <= 0;
			pending        <= 0;
			beats_checked  <= 0;
			stream_ends    <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PATTERN_BYTES: pattern_word = cfg_data;
					REG_PATTERN_LENGTH: begin
						// held bytes are dropped
						pattern_len_reg = cfg_data[LEN_W-1:0];
						held_bytes      = '{default: 8'h00};
						held_count      = 0;
					end
					REG_REPLACEMENT_BYTES: repl_word = cfg_data;
					REG_REPLACEMENT_LEN: repl_len_reg = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (feed_valid && feed_ready)
				predict_results(feed_beat);
			if (result_valid && result_ready)
				check_result(result_beat);
			errors        <= err_count;
			pending       <= expected_out_q.size();
			beats_checked <= checked_count;
			stream_ends   <= end_count;
		end
	end

endmodule

`default_nettype wire

// ===== verif/byte_stream_find_replace_tb.sv =====
// ----------------------------------------------------------------------------
// byte_stream_find_replace_tb
// Stimulus and verdict for the byte stream find and replace block.
// A directed opening covers the default setting, the bare end marker, the
// longest pattern and replacement, saturating lengths and the dropping of
// held bytes on a pattern length write. Random phases then change the
// registers while the block is idle and feed streams that are rich in pattern
// runs, some of them broken. Both sides idle at random, and the receiver
// holds off for long stretches so that the block backs up. The checker
// module does the prediction and comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stream_find_replace_tb;
	import bsfr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_TARGET = 260;
	localparam int HOLD_CYCLES   = 64;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int  chk_errors;
	int  chk_pending;
	int  chk_checked;
	int  chk_stream_ends;

	int          beats_sent;
	int          settings_used;
	int          hold_req;
	bit          no_idle;
	logic [63:0] cur_pattern;
	int unsigned cur_span;

	bsfr_stream_if #(.payload_t(in_beat_t))  feed_if ();
	bsfr_stream_if #(.payload_t(out_beat_t)) result_if ();

	byte_stream_find_replace i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.feed      (feed_if.sink),
		.result    (result_if.source)
	);

	byte_stream_find_replace_chk i_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.feed_valid    (feed_if.valid),
		.feed_ready    (feed_if.ready),
		.feed_beat     (feed_if.payload),
		.result_valid  (result_if.valid),
		.result_ready  (result_if.ready),
		.result_beat   (result_if.payload),
		.errors        (chk_errors),
		.pending       (chk_pending),
		.beats_checked (chk_checked),
		.stream_ends   (chk_stream_ends)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// receiver: random stalls, forced hold-off on request
	initial begin
		int  rx_left;
		int  gap;
		int  hold_left;
		int  hold_seen;
		bit  rx_level;
		result_if.ready <= 1'b0;
		rx_left   = 0;
		hold_left = 0;
		hold_seen = 0;
		rx_level  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else if (no_idle) begin
				result_if.ready <= 1'b1;
			end else begin
				if (rx_left == 0) begin
					gap = pick_gap();
					if (gap > 0 && rx_level) begin
						rx_level = 1'b0;
						rx_left  = gap;
					end else begin
						rx_level = 1'b1;
						rx_left  = $urandom_range(1, 12);
					end
				end
				result_if.ready <= rx_level;
				rx_left--;
			end
		end
	end

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic configure(input logic [3:0] mask, input logic [63:0] pat,
			input logic [LEN_W-1:0] plen, input logic [63:0] rep,
			input logic [LEN_W-1:0] rlen);
		if (mask[REG_PATTERN_BYTES]) begin
			write_reg(REG_PATTERN_BYTES, pat);
			cur_pattern = pat;
		end
		if (mask[REG_PATTERN_LENGTH]) begin
			write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(plen));
			cur_span = (plen == 0) ? 1 : ((plen > 8) ? 8 : plen);
		end
		if (mask[REG_REPLACEMENT_BYTES])
			write_reg(REG_REPLACEMENT_BYTES, rep);
		if (mask[REG_REPLACEMENT_LEN])
			write_reg(REG_REPLACEMENT_LEN, CFG_DATA_W'(rlen));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic send_beat(input logic [7:0] b, input logic eos);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			feed_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		feed_if.valid   <= 1'b1;
		feed_if.payload <= '{in_byte: b, end_of_stream: eos};
		@(posedge clk);
		while (!feed_if.ready)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic wait_drained();
		feed_if.valid <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// pattern runs, some with one byte broken, mixed with pattern bytes and noise
	task automatic send_stream(input int len, input bit close);
		int         k;
		int         r;
		int         spot;
		logic [7:0] b;
		k = 0;
		while (k < len) begin
			r = $urandom_range(0, 9);
			if (r < 5) begin
				spot = ($urandom_range(0, 4) == 0) ? $urandom_range(0, cur_span - 1) : -1;
				for (int j = 0; j < cur_span && k < len; j++) begin
					b = cur_pattern[j*8 +: 8];
					if (j == spot)
						b = b ^ 8'($urandom_range(1, 255));
					k++;
					send_beat(b, close && k == len);
				end
			end else begin
				if (r < 8)
					b = cur_pattern[$urandom_range(0, cur_span - 1)*8 +: 8];
				else
					b = 8'($urandom_range(0, 255));
				k++;
				send_beat(b, close && k == len);
			end
		end
	endtask

	initial begin
		int               phase;
		logic [3:0]       mask;
		logic [LEN_W-1:0] plen_w;
		logic [LEN_W-1:0] rlen_w;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= REG_PATTERN_BYTES;
		cfg_data        <= '0;
		feed_if.valid   <= 1'b0;
		feed_if.payload <= '0;
		beats_sent    = 0;
		settings_used = 1;
		hold_req      = 0;
		no_idle       = 1'b0;
		cur_pattern   = '0;
		cur_span      = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default setting: a zero byte is deleted, bare end marker
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b1);
		send_beat(8'h00, 1'b1);

		// longest pattern and replacement, then a flush of held bytes
		wait_drained();
		configure(4'b1111, '1, 4'd8, {$urandom, $urandom}, 4'd8);
		repeat (8) send_beat(8'hFF, 1'b0);
		send_beat(8'h01, 1'b0);
		send_beat(8'h02, 1'b0);
		send_beat(8'h03, 1'b0);
		send_beat(8'h00, 1'b1);

		// zero pattern length acts as one, replacement length saturates
		wait_drained();
		configure(4'b1111, 64'h5A, 4'd0, '0, 4'd15);
		send_beat(8'h5A, 1'b0);
		send_beat(8'h11, 1'b0);
		send_beat(8'h5A, 1'b1);

		// saturating pattern length, then a length write drops held bytes
		wait_drained();
		configure(4'b0010, '0, 4'd12, '0, '0);
		send_beat(8'h5A, 1'b0);
		send_beat(8'h00, 1'b0);
		wait_drained();
		configure(4'b0010, '0, 4'd3, '0, '0);
		send_beat(8'h77, 1'b1);

		// other writes keep held bytes
		send_beat(8'h33, 1'b0);
		wait_drained();
		configure(4'b1000, '0, '0, '0, 4'd2);
		send_beat(8'h44, 1'b1);

		phase = 0;
		while (beats_sent < RANDOM_TARGET) begin
			wait_drained();
			no_idle = ($urandom_range(0, 3) == 0);
			plen_w  = ($urandom_range(0, 9) == 0) ?
				(($urandom_range(0, 1) == 0) ? 4'd0 : LEN_W'($urandom_range(9, 15))) :
				LEN_W'($urandom_range(1, 8));
			rlen_w  = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(9, 15)) :
				LEN_W'($urandom_range(0, 8));
			mask    = 4'($urandom_range(1, 15));
			if (phase == 0) begin
				mask   = 4'b1111;
				plen_w = 4'd1;
				rlen_w = 4'd0;
			end else if (phase == 1) begin
				mask   = 4'b1111;
				plen_w = 4'd8;
				rlen_w = 4'd8;
			end
			configure(mask, {$urandom, $urandom}, plen_w, {$urandom, $urandom}, rlen_w);
			if (phase == 2 || phase == 6) begin
				no_idle = 1'b1;
				hold_req++;
			end
			repeat ($urandom_range(1, 3))
				send_stream($urandom_range(4, 30), $urandom_range(0, 9) < 7);
			phase++;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("fed %0d input beats under %0d register settings, %0d receiver hold-offs",
			beats_sent, settings_used, hold_req);
		$display("checked %0d output beats, %0d of them closing a stream",
			chk_checked, chk_stream_ends);
		if (chk_errors == 0 && chk_pending == 0)
			$display("** byte_stream_find_replace: PASSED **");
		else
			$display("** byte_stream_find_replace: FAILED **");
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout");
		$display("** byte_stream_find_replace: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/bsfr_pkg.sv
rtl/bsfr_stream_if.sv
rtl/bsfr_cell.sv
rtl/byte_stream_find_replace.sv
verif/byte_stream_find_replace_chk.sv
verif/byte_stream_find_replace_tb.sv
